/* design/ats_pkg.sv */
// Shared constants for the alias table sampler: field widths, fixed-point
// scaling and operation codes. No dependencies.
package ats_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int PROB_W          = 25;
    localparam int UNI_W           = 24;
    localparam int THR_W           = 25;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int SCALED_W        = 31;
    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [SCALED_W-1:0] ONE_FX = SCALED_W'(1) << FRAC_BITS;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_DRAW     = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DRAW   = 1'b1;

endpackage

/* design/ats_in_if.sv */
// Input channel of the alias table sampler: valid/ready plus one load or draw item.
// Depends on ats_pkg for field widths.
interface ats_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ats_pkg::PROB_W-1:0]  probability;
    logic                        last_entry;
    logic [ats_pkg::UNI_W-1:0]   uniform_index;
    logic [ats_pkg::UNI_W-1:0]   uniform_threshold;

    modport source (output valid, op, probability, last_entry, uniform_index,
                    uniform_threshold, input ready);
    modport sink   (input valid, op, probability, last_entry, uniform_index,
                    uniform_threshold, output ready);
endinterface

/* design/ats_out_if.sv */
// Result channel of the alias table sampler: valid/ready plus one report or draw result.
// Depends on ats_pkg for field widths.
interface ats_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ats_pkg::IDX_W-1:0]   entry_index;
    logic [ats_pkg::IDX_W-1:0]   alias_index;
    logic [ats_pkg::THR_W-1:0]   threshold;
    logic [ats_pkg::IDX_W-1:0]   drawn_index;
    logic                        last_result;

    modport source (output valid, kind, entry_index, alias_index, threshold,
                    drawn_index, last_result, input ready);
    modport sink   (input valid, kind, entry_index, alias_index, threshold,
                    drawn_index, last_result, output ready);
endinterface

/* design/alias_table_sampler_unit.sv */
// Load: a new item every cycle while idle. Draw: the entry memories are read at
//   the drawn column; DR_OUT registers the result once the output register is free.
// Build after the last load of N entries: scaling of each entry, pairing steps
//   (at most N-1), leftover entries, then one report per entry; no input is taken
//   during a draw or a build until its result or its last report is registered.
// Reset clears the counters and the table size (no table); memories are not cleared.
module alias_table_sampler_unit #(
    parameter int MAX_ENTRIES = ats_pkg::MAX_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ats_in_if.sink    i_in,
    ats_out_if.source o_out
);

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = ats_pkg::CNT_W;
    localparam int SW   = ats_pkg::SCALED_W;
    localparam int SP_W = SW + CW;
    localparam int XP_W = ats_pkg::UNI_W + CW;

    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_ENTRIES);
    localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_ENTRIES - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SC_RD  = 4'd1;
    localparam logic [3:0] S_SC_WR  = 4'd2;
    localparam logic [3:0] S_PR_POP = 4'd3;
    localparam logic [3:0] S_PR_IDX = 4'd4;
    localparam logic [3:0] S_PR_UPD = 4'd5;
    localparam logic [3:0] S_LEFT   = 4'd6;
    localparam logic [3:0] S_RP_RD  = 4'd7;
    localparam logic [3:0] S_RP_OUT = 4'd8;
    localparam logic [3:0] S_DR_OUT = 4'd9;

    // control state
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_entry_cnt, n_entry_cnt;
    logic [CW-1:0] r_tsize, n_tsize;
    logic [CW-1:0] r_uc, n_uc;
    logic [CW-1:0] r_oc, n_oc;
    logic          r_lv, n_lv;
    logic          r_o_valid, n_o_valid;

    // datapath state
    logic [AW-1:0]               r_idx, n_idx;
    logic [AW-1:0]               r_s, n_s;
    logic [AW-1:0]               r_l, n_l;
    logic [AW-1:0]               r_x, n_x;
    logic                        r_empty, n_empty;
    logic [ats_pkg::UNI_W-1:0]   r_uthr, n_uthr;
    logic                        r_o_kind, n_o_kind;
    logic [ats_pkg::IDX_W-1:0]   r_o_entry, n_o_entry;
    logic [ats_pkg::IDX_W-1:0]   r_o_alias, n_o_alias;
    logic [ats_pkg::THR_W-1:0]   r_o_thr, n_o_thr;
    logic [ats_pkg::IDX_W-1:0]   r_o_drawn, n_o_drawn;
    logic                        r_o_last, n_o_last;

    // memory ports
    logic          sc_we;
    logic [AW-1:0] sc_waddr, sc_raddr_a, sc_raddr_b;
    logic [SW-1:0] sc_wdata, sc_rdata_a, sc_rdata_b;
    logic          al_we;
    logic [AW-1:0] al_waddr, al_wdata, al_raddr, al_rdata;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_wdata, st_raddr_a, st_raddr_b, st_rdata_a, st_rdata_b;

    // arithmetic
    logic          in_fire;
    logic          out_free;
    logic          cnt_inc;
    logic [CW-1:0] cnt_new;
    logic [XP_W-1:0] x_prod;
    logic [CW-1:0] x_raw, x_sat;
    logic [AW-1:0] draw_addr;
    logic [SP_W-1:0] sc_prod;
    logic [SW-1:0] sc_new;
    logic          sc_under;
    logic [SW-1:0] pr_new;
    logic          pr_under;
    logic          idx_last;
    logic [AW-1:0] under_top, over_top, over_push;

    ats_ram_2r #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_scaled_ram (
        .i_clk     (i_clk),
        .i_we      (sc_we),
        .i_waddr   (sc_waddr),
        .i_wdata   (sc_wdata),
        .i_raddr_a (sc_raddr_a),
        .i_raddr_b (sc_raddr_b),
        .o_rdata_a (sc_rdata_a),
        .o_rdata_b (sc_rdata_b)
    );

    ats_ram_1r #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_alias_ram (
        .i_clk   (i_clk),
        .i_we    (al_we),
        .i_waddr (al_waddr),
        .i_wdata (al_wdata),
        .i_raddr (al_raddr),
        .o_rdata (al_rdata)
    );

    // under stack grows up from address 0, over stack grows down from the top
    ats_ram_2r #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_stack_ram (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_waddr   (st_waddr),
        .i_wdata   (st_wdata),
        .i_raddr_a (st_raddr_a),
        .i_raddr_b (st_raddr_b),
        .o_rdata_a (st_rdata_a),
        .o_rdata_b (st_rdata_b)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid & i_in.ready;
    assign out_free   = ~r_o_valid | o_out.ready;

    assign cnt_inc = (r_entry_cnt < MAX_CNT);
    assign cnt_new = r_entry_cnt + CW'(cnt_inc);

    // column = floor(u * N), saturated to N-1
    assign x_prod    = XP_W'(i_in.uniform_index) * XP_W'(r_tsize);
    assign x_raw     = CW'(x_prod >> ats_pkg::FRAC_BITS);
    assign x_sat     = (x_raw >= r_tsize) ? (r_tsize - CW'(1)) : x_raw;
    assign draw_addr = AW'(x_sat);

    assign sc_prod  = SP_W'(sc_rdata_a) * SP_W'(r_tsize);
    assign sc_new   = sc_prod[SW-1:0];
    assign sc_under = (sc_new < ats_pkg::ONE_FX);

    // large plus small minus one; port A holds the small entry, port B the large one
    assign pr_new   = sc_rdata_b + sc_rdata_a - ats_pkg::ONE_FX;
    assign pr_under = (pr_new < ats_pkg::ONE_FX);

    assign idx_last  = (CW'(r_idx) == (r_tsize - CW'(1)));
    assign under_top = AW'(r_uc - CW'(1));
    assign over_top  = TOP_ADDR - AW'(r_oc - CW'(1));
    assign over_push = TOP_ADDR - AW'(r_oc);

    // memory port steering
    always_comb begin
        sc_we      = 1'b0;
        sc_waddr   = r_idx;
        sc_wdata   = ats_pkg::ONE_FX;
        sc_raddr_a = r_idx;
        sc_raddr_b = r_l;
        al_we      = 1'b0;
        al_waddr   = r_idx;
        al_wdata   = '0;
        al_raddr   = r_idx;
        st_we      = 1'b0;
        st_waddr   = AW'(r_uc);
        st_wdata   = r_idx;
        st_raddr_a = under_top;
        st_raddr_b = over_top;
        case (r_state)
            S_IDLE: begin
                sc_raddr_a = draw_addr;
                al_raddr   = draw_addr;
                if (in_fire && (i_in.op == ats_pkg::OP_LOAD) && cnt_inc) begin
                    sc_we    = 1'b1;
                    sc_waddr = AW'(r_entry_cnt);
                    sc_wdata = SW'(i_in.probability);
                end
            end
            S_SC_WR: begin
                sc_we    = 1'b1;
                sc_wdata = sc_new;
                al_we    = 1'b1;
                st_we    = 1'b1;
                st_waddr = sc_under ? AW'(r_uc) : over_push;
                st_wdata = r_idx;
            end
            S_PR_IDX: begin
                sc_raddr_a = st_rdata_a;
                sc_raddr_b = st_rdata_b;
            end
            S_PR_UPD: begin
                al_we    = 1'b1;
                al_waddr = r_s;
                al_wdata = r_l;
                sc_we    = 1'b1;
                sc_waddr = r_l;
                sc_wdata = pr_new;
                st_we    = 1'b1;
                st_waddr = pr_under ? AW'(r_uc) : over_push;
                st_wdata = r_l;
            end
            S_LEFT: begin
                sc_we      = r_lv;
                sc_waddr   = st_rdata_a;
                st_raddr_a = (r_uc != '0) ? under_top : over_top;
            end
            S_DR_OUT: begin
                sc_raddr_a = r_x;
                al_raddr   = r_x;
            end
            default: begin
            end
        endcase
    end

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_entry_cnt = r_entry_cnt;
        n_tsize     = r_tsize;
        n_uc        = r_uc;
        n_oc        = r_oc;
        n_lv        = r_lv;
        n_idx       = r_idx;
        n_s         = r_s;
        n_l         = r_l;
        n_x         = r_x;
        n_empty     = r_empty;
        n_uthr      = r_uthr;
        n_o_valid   = r_o_valid & ~o_out.ready;
        n_o_kind    = r_o_kind;
        n_o_entry   = r_o_entry;
        n_o_alias   = r_o_alias;
        n_o_thr     = r_o_thr;
        n_o_drawn   = r_o_drawn;
        n_o_last    = r_o_last;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.op == ats_pkg::OP_LOAD) begin
                        // first load of a new set drops the current table
                        if (r_entry_cnt == '0) begin
                            n_tsize = '0;
                        end
                        if (i_in.last_entry) begin
                            n_entry_cnt = '0;
                            n_tsize     = cnt_new;
                            n_idx       = '0;
                            n_uc        = '0;
                            n_oc        = '0;
                            n_state     = S_SC_RD;
                        end else begin
                            n_entry_cnt = cnt_new;
                        end
                    end else begin
                        n_uthr  = i_in.uniform_threshold;
                        n_x     = draw_addr;
                        n_empty = (r_tsize == '0);
                        n_state = S_DR_OUT;
                    end
                end
            end
            S_DR_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = ats_pkg::KIND_DRAW;
                    n_o_last  = 1'b1;
                    if (r_empty) begin
                        n_o_entry = '0;
                        n_o_alias = '0;
                        n_o_thr   = '0;
                        n_o_drawn = '0;
                    end else begin
                        n_o_entry = ats_pkg::IDX_W'(r_x);
                        n_o_alias = ats_pkg::IDX_W'(al_rdata);
                        n_o_thr   = sc_rdata_a[ats_pkg::THR_W-1:0];
                        n_o_drawn = (SW'(r_uthr) < sc_rdata_a) ? ats_pkg::IDX_W'(r_x)
                                                                : ats_pkg::IDX_W'(al_rdata);
                    end
                    n_state = S_IDLE;
                end
            end
            S_SC_RD: begin
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                if (sc_under) begin
                    n_uc = r_uc + CW'(1);
                end else begin
                    n_oc = r_oc + CW'(1);
                end
                if (idx_last) begin
                    n_state = S_PR_POP;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_PR_POP: begin
                if ((r_uc == '0) || (r_oc == '0)) begin
                    n_lv    = 1'b0;
                    n_state = S_LEFT;
                end else begin
                    n_uc    = r_uc - CW'(1);
                    n_oc    = r_oc - CW'(1);
                    n_state = S_PR_IDX;
                end
            end
            S_PR_IDX: begin
                n_s     = st_rdata_a;
                n_l     = st_rdata_b;
                n_state = S_PR_UPD;
            end
            S_PR_UPD: begin
                if (pr_under) begin
                    n_uc = r_uc + CW'(1);
                end else begin
                    n_oc = r_oc + CW'(1);
                end
                n_state = S_PR_POP;
            end
            S_LEFT: begin
                // pop one leftover a cycle; its write lands in the following cycle
                if (r_uc != '0) begin
                    n_uc = r_uc - CW'(1);
                    n_lv = 1'b1;
                end else if (r_oc != '0) begin
                    n_oc = r_oc - CW'(1);
                    n_lv = 1'b1;
                end else begin
                    n_lv    = 1'b0;
                    n_idx   = '0;
                    n_state = S_RP_RD;
                end
            end
            S_RP_RD: begin
                n_state = S_RP_OUT;
            end
            S_RP_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = ats_pkg::KIND_REPORT;
                    n_o_entry = ats_pkg::IDX_W'(r_idx);
                    n_o_alias = ats_pkg::IDX_W'(al_rdata);
                    n_o_thr   = sc_rdata_a[ats_pkg::THR_W-1:0];
                    n_o_drawn = '0;
                    n_o_last  = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entry_cnt <= '0;
            r_tsize     <= '0;
            r_uc        <= '0;
            r_oc        <= '0;
            r_lv        <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry_cnt <= n_entry_cnt;
            r_tsize     <= n_tsize;
            r_uc        <= n_uc;
            r_oc        <= n_oc;
            r_lv        <= n_lv;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_s       <= n_s;
        r_l       <= n_l;
        r_x       <= n_x;
        r_empty   <= n_empty;
        r_uthr    <= n_uthr;
        r_o_kind  <= n_o_kind;
        r_o_entry <= n_o_entry;
        r_o_alias <= n_o_alias;
        r_o_thr   <= n_o_thr;
        r_o_drawn <= n_o_drawn;
        r_o_last  <= n_o_last;
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.kind        = r_o_kind;
    assign o_out.entry_index = r_o_entry;
    assign o_out.alias_index = r_o_alias;
    assign o_out.threshold   = r_o_thr;
    assign o_out.drawn_index = r_o_drawn;
    assign o_out.last_result = r_o_last;

endmodule

/* design/ats_ram_1r.sv */
// Synchronous RAM with one write port and one registered read port.
// Depends on ats_pkg for default sizes.
module ats_ram_1r #(
    parameter int WIDTH  = ats_pkg::IDX_W,
    parameter int DEPTH  = ats_pkg::MAX_ENTRIES_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ats_ram_2r.sv */
// Synchronous RAM with one write port and two registered read ports.
// Depends on ats_pkg for default sizes.
module ats_ram_2r #(
    parameter int WIDTH  = ats_pkg::SCALED_W,
    parameter int DEPTH  = ats_pkg::MAX_ENTRIES_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
